// ===== hw/rtl/laplacian_zero_crossing_detector_core_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the Laplacian zero-crossing detector
// Concurrent assertion wrappers, compiled out when ASSERT_OFF is defined.
// ----------------------------------------------------------------------------
`ifndef LAPLACIAN_ZERO_CROSSING_DETECTOR_CORE_MACROS_SVH
`define LAPLACIAN_ZERO_CROSSING_DETECTOR_CORE_MACROS_SVH

`ifndef ASSERT_OFF

// check with the asynchronous reset masking the property
`define LZCD_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("lzcd assertion failed");

// check that also runs while reset is asserted
`define LZCD_ASSERT_RST(label, clk, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("lzcd reset assertion failed");

`else

`define LZCD_ASSERT(label, clk, rst_n, prop)
`define LZCD_ASSERT_RST(label, clk, prop)

`endif

`endif

// ===== hw/rtl/lzcd_pkg.sv =====
// ----------------------------------------------------------------------------
// Laplacian zero-crossing detector package
// Shared constants, register indexes and the position flag type.
// ----------------------------------------------------------------------------
package lzcd_pkg;

    localparam int MAX_WIDTH_DEF   = 2048;
    localparam int SAMPLE_BITS_DEF = 12;

    localparam int CFG_W     = 12;
    localparam int CFG_IDX_W = 1;
    localparam int PIXEL_W   = 8;

    localparam logic [CFG_IDX_W-1:0] CFG_IDX_LINE_WIDTH     = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_EDGE_THRESHOLD = 1'b1;

    localparam logic [CFG_W-1:0] LINE_WIDTH_RESET     = 12'd512;
    localparam logic [CFG_W-1:0] EDGE_THRESHOLD_RESET = 12'd16;

    localparam logic [PIXEL_W-1:0] EDGE_ON  = 8'd255;
    localparam logic [PIXEL_W-1:0] EDGE_OFF = 8'd0;

    typedef struct packed {
        logic first_row;
        logic first_col;
        logic last_col;
    } pos_flags_t;

endpackage

// ===== hw/rtl/laplacian_zero_crossing_detector_core.sv =====
// ----------------------------------------------------------------------------
// Laplacian zero-crossing detector core
// Marks pixels where the Laplacian changes sign by more than a threshold.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall, sample, start_of_frame) takes one
//   Laplacian value per transaction in raster order; start_of_frame marks the
//   first pixel of an image. Output channel (out_valid / out_stall,
//   edge_pixel, row_end) returns one transaction per input: 255 or 0, with
//   row_end on the last pixel of each row.
//   Throughput is one pixel per clock while the output does not stall. A
//   pixel is held in the first stage, then in the output register. The line
//   store is read and written at the same address in the accept cycle, which
//   sets the first stage; the neighbour compare and threshold set the second.
//   A stalled output holds its transaction; one more pixel waits in the
//   middle stage, and then in_stall rises until the output drains.
//   Reset empties the pipeline, restarts the first row and loads
//   line_width 512 and edge_threshold 16. The line store is not cleared:
//   the first row of a frame never uses it. Write cfg_index 0 for the
//   line width and 1 for the threshold, only while the core is idle.
// ----------------------------------------------------------------------------
`include "laplacian_zero_crossing_detector_core_macros.svh"

module laplacian_zero_crossing_detector_core #(
    parameter int MAX_WIDTH   = lzcd_pkg::MAX_WIDTH_DEF,
    parameter int SAMPLE_BITS = lzcd_pkg::SAMPLE_BITS_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic [lzcd_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [lzcd_pkg::CFG_W-1:0]         cfg_data,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic signed [SAMPLE_BITS-1:0]      sample,
    input  logic                               start_of_frame,
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic [lzcd_pkg::PIXEL_W-1:0]       edge_pixel,
    output logic                               row_end
);

    import lzcd_pkg::*;

    localparam int COL_W = $clog2(MAX_WIDTH);

    logic [CFG_W-1:0]              line_width_reg;
    logic [CFG_W-1:0]              edge_threshold_reg;

    logic                          in_accept;
    logic                          out_ready;
    logic                          s1_advance;
    logic [COL_W-1:0]              col;
    pos_flags_t                    flags;
    logic signed [SAMPLE_BITS-1:0] above;
    logic                          edge_hit;

    logic signed [SAMPLE_BITS-1:0] left_reg;
    logic                          s1_valid_reg;
    logic                          s1_valid_next;
    logic signed [SAMPLE_BITS-1:0] s1_sample_reg;
    logic signed [SAMPLE_BITS-1:0] s1_left_reg;
    pos_flags_t                    s1_flags_reg;

    logic                          out_valid_reg;
    logic                          out_valid_next;
    logic [PIXEL_W-1:0]            edge_pixel_reg;
    logic                          row_end_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_width_reg     <= LINE_WIDTH_RESET;
            edge_threshold_reg <= EDGE_THRESHOLD_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_IDX_LINE_WIDTH:     line_width_reg     <= cfg_data;
                CFG_IDX_EDGE_THRESHOLD: edge_threshold_reg <= cfg_data;
                default:                line_width_reg     <= line_width_reg;
            endcase
        end
    end

    assign out_ready  = !out_valid_reg || !out_stall;
    assign s1_advance = s1_valid_reg && out_ready;
    assign in_stall   = s1_valid_reg && !out_ready;
    assign in_accept  = in_valid && !in_stall;

    lzcd_col_track #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_col_track (
        .clk            (clk),
        .rst_n          (rst_n),
        .advance        (in_accept),
        .start_of_frame (start_of_frame),
        .line_width     (line_width_reg),
        .col            (col),
        .flags          (flags)
    );

    lzcd_line_store #(
        .DEPTH  (MAX_WIDTH),
        .DATA_W (SAMPLE_BITS)
    ) u_line_store (
        .clk   (clk),
        .en    (in_accept),
        .addr  (col),
        .wdata (sample),
        .rdata (above)
    );

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (in_accept)
            s1_valid_next = 1'b1;
        else if (s1_advance)
            s1_valid_next = 1'b0;

        out_valid_next = out_valid_reg;
        if (s1_advance)
            out_valid_next = 1'b1;
        else if (out_valid_reg && !out_stall)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            left_reg      <= '0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
            if (in_accept)
                left_reg <= sample;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_sample_reg <= sample;
            s1_left_reg   <= left_reg;
            s1_flags_reg  <= flags;
        end
        if (s1_advance)
        begin
            edge_pixel_reg <= edge_hit ? EDGE_ON : EDGE_OFF;
            row_end_reg    <= s1_flags_reg.last_col;
        end
    end

    lzcd_edge_eval #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_edge_eval (
        .sample    (s1_sample_reg),
        .left      (s1_left_reg),
        .above     (above),
        .threshold (edge_threshold_reg),
        .flags     (s1_flags_reg),
        .edge_hit  (edge_hit)
    );

    assign out_valid  = out_valid_reg;
    assign edge_pixel = edge_pixel_reg;
    assign row_end    = row_end_reg;

    `LZCD_ASSERT(a_stall_only_when_full, clk, rst_n, in_stall |-> s1_valid_reg)
    `LZCD_ASSERT(a_edge_code, clk, rst_n, out_valid_reg |-> (edge_pixel_reg == EDGE_ON || edge_pixel_reg == EDGE_OFF))
    `LZCD_ASSERT(a_no_edge_on_border, clk, rst_n, (s1_valid_reg && (s1_flags_reg.first_row || s1_flags_reg.first_col)) |-> !edge_hit)
    `LZCD_ASSERT_RST(a_reset_empties, clk, !rst_n |-> (!out_valid_reg && !s1_valid_reg))

endmodule

// ===== hw/rtl/lzcd_line_store.sv =====
// ----------------------------------------------------------------------------
// Line store
// One-row sample memory, read-before-write at a single address per cycle.
// ----------------------------------------------------------------------------
module lzcd_line_store #(
    parameter int DEPTH  = lzcd_pkg::MAX_WIDTH_DEF,
    parameter int DATA_W = lzcd_pkg::SAMPLE_BITS_DEF
) (
    input  logic                     clk,
    input  logic                     en,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [DATA_W-1:0]        wdata,
    output logic [DATA_W-1:0]        rdata
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rdata_reg <= mem[addr];
            mem[addr] <= wdata;
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== hw/rtl/lzcd_col_track.sv =====
// ----------------------------------------------------------------------------
// Column tracker
// Keeps the raster position and flags first row, first and last column.
// ----------------------------------------------------------------------------
`include "laplacian_zero_crossing_detector_core_macros.svh"

module lzcd_col_track #(
    parameter int MAX_WIDTH = lzcd_pkg::MAX_WIDTH_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         advance,
    input  logic                         start_of_frame,
    input  logic [lzcd_pkg::CFG_W-1:0]   line_width,
    output logic [$clog2(MAX_WIDTH)-1:0] col,
    output lzcd_pkg::pos_flags_t         flags
);

    import lzcd_pkg::*;

    localparam int COL_W = $clog2(MAX_WIDTH);
    localparam int CMP_W = (COL_W + 1 > CFG_W) ? COL_W + 1 : CFG_W;

    logic [COL_W-1:0] column_reg;
    logic [COL_W-1:0] column_next;
    logic             first_row_reg;
    logic             first_row_next;
    logic [COL_W-1:0] col_cur;
    logic             first_cur;
    logic [CMP_W-1:0] width_ext;
    logic [CMP_W-1:0] width_eff;
    logic             last_cur;

    always_comb
    begin
        col_cur   = start_of_frame ? '0 : column_reg;
        first_cur = start_of_frame | first_row_reg;
        width_ext = CMP_W'(line_width);
        priority if (width_ext == '0)
            width_eff = CMP_W'(1);
        else if (width_ext > CMP_W'(MAX_WIDTH))
            width_eff = CMP_W'(MAX_WIDTH);
        else
            width_eff = width_ext;
        last_cur = (CMP_W'(col_cur) + CMP_W'(1)) >= width_eff;
    end

    always_comb
    begin
        column_next    = column_reg;
        first_row_next = first_row_reg;
        if (advance)
        begin
            if (last_cur)
            begin
                column_next    = '0;
                first_row_next = 1'b0;
            end
            else
            begin
                column_next    = col_cur + COL_W'(1);
                first_row_next = first_cur;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            column_reg    <= '0;
            first_row_reg <= 1'b1;
        end
        else
        begin
            column_reg    <= column_next;
            first_row_reg <= first_row_next;
        end
    end

    assign col             = col_cur;
    assign flags.first_row = first_cur;
    assign flags.first_col = (col_cur == '0);
    assign flags.last_col  = last_cur;

    `LZCD_ASSERT(a_wrap_on_last, clk, rst_n, (advance && flags.last_col) |=> (column_reg == '0 && !first_row_reg))
    `LZCD_ASSERT(a_step_in_row, clk, rst_n, (advance && !flags.last_col) |=> (column_reg == $past(col) + COL_W'(1)))

endmodule

// ===== hw/rtl/lzcd_edge_eval.sv =====
// ----------------------------------------------------------------------------
// Edge evaluator
// Zero-crossing test against left and upper neighbours, then threshold.
// ----------------------------------------------------------------------------
module lzcd_edge_eval #(
    parameter int SAMPLE_BITS = lzcd_pkg::SAMPLE_BITS_DEF
) (
    input  logic signed [SAMPLE_BITS-1:0] sample,
    input  logic signed [SAMPLE_BITS-1:0] left,
    input  logic signed [SAMPLE_BITS-1:0] above,
    input  logic [lzcd_pkg::CFG_W-1:0]    threshold,
    input  lzcd_pkg::pos_flags_t          flags,
    output logic                          edge_hit
);

    import lzcd_pkg::*;

    localparam int DIFF_W = SAMPLE_BITS + 1;
    localparam int CMP_W  = (DIFF_W > CFG_W) ? DIFF_W : CFG_W;

    logic              x_pos, x_neg, l_pos, l_neg, a_pos, a_neg;
    logic              left_cross, above_cross;
    logic [DIFF_W-1:0] diff_left, diff_above;
    logic [DIFF_W-1:0] mag_left, mag_above;
    logic [DIFF_W-1:0] cand_left, cand_above, best;

    always_comb
    begin
        x_neg = sample[SAMPLE_BITS-1];
        x_pos = !x_neg && (|sample);
        l_neg = left[SAMPLE_BITS-1];
        l_pos = !l_neg && (|left);
        a_neg = above[SAMPLE_BITS-1];
        a_pos = !a_neg && (|above);

        left_cross  = (x_pos && l_neg) || (x_neg && l_pos);
        above_cross = (x_pos && a_neg) || (x_neg && a_pos);

        diff_left  = {sample[SAMPLE_BITS-1], sample} - {left[SAMPLE_BITS-1], left};
        diff_above = {sample[SAMPLE_BITS-1], sample} - {above[SAMPLE_BITS-1], above};
        mag_left   = diff_left[DIFF_W-1] ? (~diff_left + DIFF_W'(1)) : diff_left;
        mag_above  = diff_above[DIFF_W-1] ? (~diff_above + DIFF_W'(1)) : diff_above;

        cand_left  = left_cross ? mag_left : '0;
        cand_above = above_cross ? mag_above : '0;
        best       = (cand_above > cand_left) ? cand_above : cand_left;

        edge_hit = !(flags.first_row || flags.first_col)
                   && (CMP_W'(best) > CMP_W'(threshold));
    end

endmodule

// ===== dv/edge_mark_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Edge mark checker
// Watches the register port and both pixel channels of the zero-crossing
// detector, predicts the mark and row end of every accepted pixel and
// compares each output transaction with the oldest prediction in order.
// ----------------------------------------------------------------------------
module edge_mark_checker (
    input  logic                                         clk,
    input  logic                                         rst_n,
    input  logic                                         cfg_we,
    input  logic [lzcd_pkg::CFG_IDX_W-1:0]               cfg_index,
    input  logic [lzcd_pkg::CFG_W-1:0]                   cfg_data,
    input  logic                                         in_valid,
    input  logic                                         in_stall,
    input  logic signed [lzcd_pkg::SAMPLE_BITS_DEF-1:0]  sample,
    input  logic                                         start_of_frame,
    input  logic                                         out_valid,
    input  logic                                         out_stall,
    input  logic [lzcd_pkg::PIXEL_W-1:0]                 edge_pixel,
    input  logic                                         row_end,
    output int                                           pending_marks,
    output int                                           fail_count
);

    import lzcd_pkg::*;

    typedef struct packed {
        logic [PIXEL_W-1:0] edge_pixel;
        logic               row_end;
    } pixel_mark_t;

    int             row_above [0:MAX_WIDTH_DEF-1];
    int             left_value;
    int             column_pos;
    bit             first_row;
    logic [CFG_W-1:0] line_width;
    logic [CFG_W-1:0] edge_threshold;
    pixel_mark_t    expected_marks [$];

    function automatic bit opposite_signs(input int a, input int b);
        return (a > 0 && b < 0) || (a < 0 && b > 0);
    endfunction

    function automatic int spread(input int a, input int b);
        return (a > b) ? a - b : b - a;
    endfunction

    function automatic pixel_mark_t mark_pixel(input logic signed [SAMPLE_BITS_DEF-1:0] value,
                                               input logic sof);
        int          x;
        int          above;
        int          best;
        int          width;
        int          col;
        pixel_mark_t mark;
        x     = value;
        best  = 0;
        if (sof)
        begin
            column_pos = 0;
            first_row  = 1'b1;
        end
        width = line_width;
        if (width == 0)
            width = 1;
        if (width > MAX_WIDTH_DEF)
            width = MAX_WIDTH_DEF;
        col   = column_pos;
        above = row_above[col];
        if (!first_row && col != 0)
        begin
            if (opposite_signs(x, left_value))
                best = spread(x, left_value);
            if (opposite_signs(x, above) && spread(x, above) > best)
                best = spread(x, above);
        end
        mark.edge_pixel = (best > int'(edge_threshold)) ? EDGE_ON : EDGE_OFF;
        mark.row_end    = (col + 1 >= width);
        row_above[col]  = x;
        left_value      = x;
        if (mark.row_end)
        begin
            column_pos = 0;
            first_row  = 1'b0;
        end
        else
        begin
            column_pos = col + 1;
        end
        return mark;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        pixel_mark_t want;
        if (!rst_n)
        begin
            left_value     = 0;
            column_pos     = 0;
            first_row      = 1'b1;
            line_width     = LINE_WIDTH_RESET;
            edge_threshold = EDGE_THRESHOLD_RESET;
            fail_count     = 0;
            expected_marks.delete();
            pending_marks <= 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_IDX_LINE_WIDTH:     line_width     = cfg_data;
                    CFG_IDX_EDGE_THRESHOLD: edge_threshold = cfg_data;
                    default: ;
                endcase
            end
            if (out_valid && !out_stall)
            begin
                if (expected_marks.size() == 0)
                begin
                    $error("unexpected output transaction: edge_pixel %0d row_end %0d",
                           edge_pixel, row_end);
                    fail_count++;
                end
                else
                begin
                    want = expected_marks.pop_front();
                    if (edge_pixel !== want.edge_pixel)
                    begin
                        $error("edge_pixel mismatch: expected %0d, actual %0d",
                               want.edge_pixel, edge_pixel);
                        fail_count++;
                    end
                    if (row_end !== want.row_end)
                    begin
                        $error("row_end mismatch: expected %0d, actual %0d",
                               want.row_end, row_end);
                        fail_count++;
                    end
                end
            end
            if (in_valid && !in_stall)
                expected_marks.push_back(mark_pixel(sample, start_of_frame));
            pending_marks <= expected_marks.size();
        end
    end

endmodule

// ===== dv/laplacian_zero_crossing_detector_core_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Laplacian zero-crossing detector testbench
// Streams directed and random Laplacian frames through the core under a
// series of line widths and thresholds, with random gaps on the input and
// random output back-pressure; the edge mark checker scores every result.
// ----------------------------------------------------------------------------
module laplacian_zero_crossing_detector_core_tb;
    import lzcd_pkg::*;

    localparam int CYCLE_LIMIT = 500000;

    logic                               clk;
    logic                               rst_n;
    logic                               cfg_we;
    logic [CFG_IDX_W-1:0]               cfg_index;
    logic [CFG_W-1:0]                   cfg_data;
    logic                               in_valid;
    logic                               in_stall;
    logic signed [SAMPLE_BITS_DEF-1:0]  sample;
    logic                               start_of_frame;
    logic                               out_valid;
    logic                               out_stall;
    logic [PIXEL_W-1:0]                 edge_pixel;
    logic                               row_end;

    int pending_marks;
    int fail_count;
    int cycle_count = 0;
    int last_sample = 0;
    int cur_thr     = 16;
    int random_items;
    bit idling      = 1'b0;
    bit calm        = 1'b0;

    laplacian_zero_crossing_detector_core uut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .sample         (sample),
        .start_of_frame (start_of_frame),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .edge_pixel     (edge_pixel),
        .row_end        (row_end)
    );

    edge_mark_checker marks (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .sample         (sample),
        .start_of_frame (start_of_frame),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .edge_pixel     (edge_pixel),
        .row_end        (row_end),
        .pending_marks  (pending_marks),
        .fail_count     (fail_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    initial
    begin
        out_stall <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (idling && $urandom_range(0, 9) == 0)
            begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 11)) @(posedge clk);
                out_stall <= 1'b0;
            end
        end
    end

    function automatic logic signed [SAMPLE_BITS_DEF-1:0] next_sample();
        int v;
        case ($urandom_range(0, 9))
            0: v = 2047;
            1: v = -2048;
            2: v = 0;
            3, 4: v = int'($urandom_range(0, 80)) - 40;
            5, 6:
            begin
                if (last_sample > 0)
                    v = last_sample - cur_thr - int'($urandom_range(0, 1));
                else if (last_sample < 0)
                    v = last_sample + cur_thr + int'($urandom_range(0, 1));
                else
                    v = int'($urandom_range(0, 1)) * 2 - 1;
            end
            default: v = int'($urandom_range(0, 4095)) - 2048;
        endcase
        if (v > 2047)
            v = 2047;
        if (v < -2048)
            v = -2048;
        return v[SAMPLE_BITS_DEF-1:0];
    endfunction

    task automatic send_pixel(input int value, input bit sof);
        if (idling && $urandom_range(0, 9) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge clk);
        end
        in_valid       <= 1'b1;
        sample         <= value[SAMPLE_BITS_DEF-1:0];
        start_of_frame <= sof;
        last_sample     = value;
        do
            @(posedge clk);
        while (in_stall);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (pending_marks != 0);
    endtask

    task automatic configure(input int width, input int thr);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_IDX_LINE_WIDTH;
        cfg_data  <= width[CFG_W-1:0];
        @(posedge clk);
        cfg_index <= CFG_IDX_EDGE_THRESHOLD;
        cfg_data  <= thr[CFG_W-1:0];
        @(posedge clk);
        cfg_we    <= 1'b0;
        cur_thr    = thr;
    endtask

    task automatic run_phase(input int width, input int thr, input int count,
                             input bit new_frame, input bit noise);
        bit sof;
        drain();
        configure(width, thr);
        idling = !calm && ($urandom_range(0, 3) != 0);
        for (int i = 0; i < count; i++)
        begin
            sof = (new_frame && i == 0) || (noise && $urandom_range(0, 249) == 0);
            send_pixel(next_sample(), sof);
        end
    endtask

    function automatic int pick_threshold();
        case ($urandom_range(0, 5))
            0: return 0;
            1: return 4095;
            2: return 4094;
            3, 4: return $urandom_range(0, 64);
            default: return $urandom_range(0, 4095);
        endcase
    endfunction

    function automatic int pick_width();
        case ($urandom_range(0, 7))
            0: return 0;
            1: return 1;
            2: return 2;
            3: return $urandom_range(41, 300);
            default: return $urandom_range(3, 40);
        endcase
    endfunction

    initial
    begin
        rst_n          <= 1'b0;
        cfg_we         <= 1'b0;
        cfg_index      <= CFG_IDX_LINE_WIDTH;
        cfg_data       <= '0;
        in_valid       <= 1'b0;
        sample         <= '0;
        start_of_frame <= 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // first row after reset carries no start of frame
        configure(4, 16);
        send_pixel(2047, 1'b0);
        send_pixel(-2048, 1'b0);
        send_pixel(0, 1'b0);
        send_pixel(1, 1'b0);
        send_pixel(-1, 1'b0);
        send_pixel(2047, 1'b0);
        send_pixel(-2048, 1'b0);
        send_pixel(0, 1'b0);
        send_pixel(5, 1'b0);
        send_pixel(-5, 1'b0);
        send_pixel(3, 1'b0);
        send_pixel(-13, 1'b0);
        send_pixel(3, 1'b0);
        send_pixel(-14, 1'b0);
        send_pixel(50, 1'b1);
        send_pixel(-50, 1'b0);
        send_pixel(7, 1'b0);
        send_pixel(8, 1'b0);

        drain();
        configure(2, 4094);
        send_pixel(2047, 1'b1);
        send_pixel(-2048, 1'b0);
        send_pixel(-2048, 1'b0);
        send_pixel(2047, 1'b0);
        drain();
        configure(2, 4095);
        send_pixel(-2048, 1'b0);
        send_pixel(2047, 1'b0);

        // shrink the width mid-row: at the current column, then past it
        run_phase(12, 20, 33, 1'b1, 1'b0);
        run_phase(9, 20, 20, 1'b0, 1'b0);
        run_phase(12, 20, 22, 1'b1, 1'b0);
        run_phase(3, 20, 15, 1'b0, 1'b0);

        run_phase(2048, pick_threshold(), 30, 1'b1, 1'b1);

        random_items = 0;
        while (random_items < 1000)
        begin
            int count;
            count = $urandom_range(60, 180);
            run_phase(pick_width(), pick_threshold(), count, 1'b1, 1'b1);
            random_items += count;
        end

        run_phase(4095, 30, 200, 1'b1, 1'b0);

        calm = 1'b1;
        run_phase($urandom_range(3, 20), pick_threshold(), 120, 1'b1, 1'b1);

        drain();
        repeat (10) @(posedge clk);
        if (fail_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+hw/rtl
hw/rtl/lzcd_pkg.sv
hw/rtl/lzcd_line_store.sv
hw/rtl/lzcd_col_track.sv
hw/rtl/lzcd_edge_eval.sv
hw/rtl/laplacian_zero_crossing_detector_core.sv
dv/edge_mark_checker.sv
dv/laplacian_zero_crossing_detector_core_tb.sv
